// File: rtl/core/blur3_pkg.sv
// Shared types, constants and tap codes for the weighted 3x3 blur unit.
package blur3_pkg;

    localparam int MAX_SIDE        = 256;
    localparam int PIXEL_BITS      = 16;

    localparam int COORD_IN_BITS   = 8;
    localparam int PIXEL_IN_BITS   = 16;
    localparam int DRAW_BITS       = 4;
    localparam int SIDE_BITS       = 9;
    localparam int SIDE_MIN        = 2;
    localparam int SIDE_RESET      = 256;
    localparam int DRAW_MIN        = 1;
    localparam int DRAW_MAX        = 10;

    localparam int COORD_BITS      = $clog2(MAX_SIDE);
    localparam int STORE_DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int STORE_ADDR_BITS = 2 * COORD_BITS;
    localparam int SIDE_CMP_BITS   = ($clog2(MAX_SIDE + 1) > SIDE_BITS) ?
                                     $clog2(MAX_SIDE + 1) : SIDE_BITS;

    localparam int WEIGHT_BITS     = 8;
    localparam int TOTAL_BITS      = 10;
    localparam int PROD_BITS       = PIXEL_BITS + WEIGHT_BITS;
    localparam int ACC_BITS        = PIXEL_BITS + TOTAL_BITS;
    localparam int QUO_BITS        = 2 * ((PIXEL_BITS + 1) / 2);
    localparam int DIV_ITERS       = QUO_BITS / 2;
    localparam int ITER_BITS       = $clog2(DIV_ITERS);
    localparam int REM_BITS        = TOTAL_BITS;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_BITS       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_BITS      = 3;
    localparam int PDATA_BITS      = 32;
    localparam logic REG_IMAGE_SIDE = 1'b0;

    localparam int TAP_BITS = 4;
    localparam logic [TAP_BITS-1:0] TAP_NW = 4'd0;
    localparam logic [TAP_BITS-1:0] TAP_N  = 4'd1;
    localparam logic [TAP_BITS-1:0] TAP_NE = 4'd2;
    localparam logic [TAP_BITS-1:0] TAP_W  = 4'd3;
    localparam logic [TAP_BITS-1:0] TAP_C  = 4'd4;
    localparam logic [TAP_BITS-1:0] TAP_E  = 4'd5;
    localparam logic [TAP_BITS-1:0] TAP_SW = 4'd6;
    localparam logic [TAP_BITS-1:0] TAP_S  = 4'd7;
    localparam logic [TAP_BITS-1:0] TAP_SE = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_BLUR,
        OP_REJECT
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [COORD_IN_BITS-1:0] row;
        logic [COORD_IN_BITS-1:0] col;
        logic [COORD_IN_BITS-1:0] ru;
        logic [COORD_IN_BITS-1:0] rdn;
        logic [COORD_IN_BITS-1:0] cl;
        logic [COORD_IN_BITS-1:0] cr;
        logic [PIXEL_BITS-1:0]    pixel;
        logic [WEIGHT_BITS-1:0]   w_corner;
        logic [WEIGHT_BITS-1:0]   w_edge;
        logic [WEIGHT_BITS-1:0]   w_center;
        logic [TOTAL_BITS-1:0]    total;
    } op_t;

    function automatic logic [DRAW_BITS-1:0] clamp_draw(input logic [DRAW_BITS-1:0] d);
        logic [DRAW_BITS-1:0] r;
        if (d < DRAW_BITS'(DRAW_MIN)) begin
            r = DRAW_BITS'(DRAW_MIN);
        end else if (d > DRAW_BITS'(DRAW_MAX)) begin
            r = DRAW_BITS'(DRAW_MAX);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/weighted_3x3_blur_random_weights_unit.sv
// Top level of the weighted 3x3 blur unit: config register, front end and back end.
//
// Input channel s_*: a load transaction (s_kind 0) writes s_pixel_value into the
// image store at (s_row, s_col); a blur transaction (s_kind 1) returns one result
// on m_* with the truncated weighted 3x3 average around (s_row, s_col), edges clamped.
// Loads outside the image are dropped; blurs outside the image return coord_error 1.
// A two-entry queue parts the front end from the back end, so s_ready stays high
// while the back end works, until two transactions wait in the queue.
// A load is written into the store as it is dequeued. A blur is dequeued, then runs
// nine single-port store reads with a multiply-add each, finishes the last
// multiply-add, runs the two-bit-per-cycle divider and hands off the result.
// The result register holds m_* steady while m_ready is low; the back end then
// waits with its next result, and the front end keeps queueing.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result and
// sets image_side to 256; store contents are undefined until loaded.
// image_side sits at APB byte address 0 and must be written only while the unit is
// idle; the unit itself does not enforce this.
module weighted_3x3_blur_random_weights_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [blur3_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [blur3_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [blur3_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  s_row,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  s_col,
    input  logic [blur3_pkg::PIXEL_IN_BITS-1:0]  s_pixel_value,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_corner_draw,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_edge_draw,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_center_draw,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [blur3_pkg::PIXEL_IN_BITS-1:0]  m_blurred_value,
    output logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_row,
    output logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_col,
    output logic                                 m_coord_error
);
    import blur3_pkg::*;

    logic [SIDE_BITS-1:0] side_reg;
    logic [SIDE_BITS-1:0] side_next;
    logic                 cfg_we;
    logic                 q_valid;
    logic                 q_pop;
    op_t                  q_op;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_SIDE);
    assign side_next = cfg_we ? pwdata[SIDE_BITS-1:0] : side_reg;
    assign prdata = (paddr[2] == REG_IMAGE_SIDE) ? PDATA_BITS'(side_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_BITS'(SIDE_RESET);
        end else begin
            side_reg <= side_next;
        end
    end

    blur3_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .side_cfg      (side_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_pixel_value (s_pixel_value),
        .s_corner_draw (s_corner_draw),
        .s_edge_draw   (s_edge_draw),
        .s_center_draw (s_center_draw),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop)
    );

    blur3_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_op            (q_op),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blurred_value (m_blurred_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_coord_error   (m_coord_error)
    );

endmodule

// File: rtl/core/blur3_front.sv
// Front end: accepts transactions, classifies them and queues decoded operations.
module blur3_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [blur3_pkg::SIDE_BITS-1:0]      side_cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  s_row,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  s_col,
    input  logic [blur3_pkg::PIXEL_IN_BITS-1:0]  s_pixel_value,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_corner_draw,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_edge_draw,
    input  logic [blur3_pkg::DRAW_BITS-1:0]      s_center_draw,
    output logic                                 q_valid,
    output blur3_pkg::op_t                       q_op,
    input  logic                                 q_pop
);
    import blur3_pkg::*;

    logic [SIDE_CMP_BITS-1:0] side_ext;
    logic [SIDE_CMP_BITS-1:0] side_eff;
    logic [SIDE_CMP_BITS-1:0] row_ext;
    logic [SIDE_CMP_BITS-1:0] col_ext;
    logic                     in_image;
    logic [WEIGHT_BITS-1:0]   w_corner;
    logic [WEIGHT_BITS-1:0]   w_edge;
    logic [WEIGHT_BITS-1:0]   w_center;
    op_t                      op_in;
    logic                     push;

    op_t                      q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]     wr_ptr_reg;
    logic [QPTR_BITS-1:0]     wr_ptr_next;
    logic [QPTR_BITS-1:0]     rd_ptr_reg;
    logic [QPTR_BITS-1:0]     rd_ptr_next;
    logic [QCOUNT_BITS-1:0]   count_reg;
    logic [QCOUNT_BITS-1:0]   count_next;

    always_comb begin
        side_ext = SIDE_CMP_BITS'(side_cfg);
        if (side_ext < SIDE_CMP_BITS'(SIDE_MIN)) begin
            side_eff = SIDE_CMP_BITS'(SIDE_MIN);
        end else if (side_ext > SIDE_CMP_BITS'(MAX_SIDE)) begin
            side_eff = SIDE_CMP_BITS'(MAX_SIDE);
        end else begin
            side_eff = side_ext;
        end
        row_ext  = SIDE_CMP_BITS'(s_row);
        col_ext  = SIDE_CMP_BITS'(s_col);
        in_image = (row_ext < side_eff) && (col_ext < side_eff);

        w_corner = WEIGHT_BITS'(clamp_draw(s_corner_draw)) << 2;
        w_edge   = WEIGHT_BITS'(clamp_draw(s_edge_draw)) << 3;
        w_center = WEIGHT_BITS'(clamp_draw(s_center_draw)) << 4;

        op_in.row      = s_row;
        op_in.col      = s_col;
        op_in.ru       = (s_row != '0) ? s_row - COORD_IN_BITS'(1) : s_row;
        op_in.rdn      = ((row_ext + SIDE_CMP_BITS'(1)) < side_eff) ?
                         s_row + COORD_IN_BITS'(1) : s_row;
        op_in.cl       = (s_col != '0) ? s_col - COORD_IN_BITS'(1) : s_col;
        op_in.cr       = ((col_ext + SIDE_CMP_BITS'(1)) < side_eff) ?
                         s_col + COORD_IN_BITS'(1) : s_col;
        op_in.pixel    = PIXEL_BITS'(s_pixel_value);
        op_in.w_corner = w_corner;
        op_in.w_edge   = w_edge;
        op_in.w_center = w_center;
        op_in.total    = (TOTAL_BITS'(w_corner) << 2) + (TOTAL_BITS'(w_edge) << 2)
                       + TOTAL_BITS'(w_center);
        if (!s_kind) begin
            op_in.kind = OP_LOAD;
        end else if (in_image) begin
            op_in.kind = OP_BLUR;
        end else begin
            op_in.kind = OP_REJECT;
        end
    end

    // drop loads outside the image
    assign s_ready = (count_reg < QCOUNT_BITS'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && (s_kind || in_image);
    assign q_valid = (count_reg != '0);
    assign q_op    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QPTR_BITS'(1);
        end
        count_next  = count_reg + QCOUNT_BITS'(push) - QCOUNT_BITS'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// File: rtl/core/blur3_back.sv
// Back end: pixel store, nine-tap weighted sum, radix-4 divider and result register.
module blur3_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  blur3_pkg::op_t                       q_op,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [blur3_pkg::PIXEL_IN_BITS-1:0]  m_blurred_value,
    output logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_row,
    output logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_col,
    output logic                                 m_coord_error
);
    import blur3_pkg::*;

    logic [PIXEL_BITS-1:0]      store_mem [STORE_DEPTH];
    logic [PIXEL_BITS-1:0]      rdata_reg;
    logic [STORE_ADDR_BITS-1:0] rd_addr;
    logic [STORE_ADDR_BITS-1:0] wr_addr;
    logic                       mem_we;

    back_state_t                state_reg;
    back_state_t                state_next;
    op_t                        op_reg;
    op_t                        op_next;
    logic [TAP_BITS-1:0]        tap_reg;
    logic [TAP_BITS-1:0]        tap_next;
    logic                       rd_valid_reg;
    logic                       rd_valid_next;
    logic [TAP_BITS-1:0]        rd_tap_reg;
    logic [TAP_BITS-1:0]        rd_tap_next;
    logic [ACC_BITS-1:0]        acc_reg;
    logic [ACC_BITS-1:0]        acc_next;
    logic [REM_BITS-1:0]        rem_reg;
    logic [REM_BITS-1:0]        rem_next;
    logic [QUO_BITS-1:0]        quo_reg;
    logic [QUO_BITS-1:0]        quo_next;
    logic [ITER_BITS-1:0]       iter_reg;
    logic [ITER_BITS-1:0]       iter_next;
    logic                       err_reg;
    logic                       err_next;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [PIXEL_IN_BITS-1:0]   out_value_reg;
    logic [PIXEL_IN_BITS-1:0]   out_value_next;
    logic [COORD_IN_BITS-1:0]   out_row_reg;
    logic [COORD_IN_BITS-1:0]   out_row_next;
    logic [COORD_IN_BITS-1:0]   out_col_reg;
    logic [COORD_IN_BITS-1:0]   out_col_next;
    logic                       out_err_reg;
    logic                       out_err_next;

    logic                       out_free;
    logic [COORD_IN_BITS-1:0]   tap_row;
    logic [COORD_IN_BITS-1:0]   tap_col;
    logic [WEIGHT_BITS-1:0]     tap_weight;
    logic [PROD_BITS-1:0]       prod;
    logic [ACC_BITS-1:0]        acc_sum;
    logic [REM_BITS-1:0]        rem_step;
    logic [QUO_BITS-1:0]        quo_step;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_op.kind)
                        OP_BLUR:   state_next = ST_READ;
                        OP_REJECT: state_next = ST_DONE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (tap_reg == TAP_SE) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DIV;
            ST_DIV: begin
                if (iter_reg == ITER_BITS'(DIV_ITERS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop  = (state_reg == ST_IDLE) && q_valid;
        mem_we = q_pop && (q_op.kind == OP_LOAD);
    end

    // tap address and weight selection
    always_comb begin
        case (tap_reg)
            TAP_NW:  begin tap_row = op_reg.ru;  tap_col = op_reg.cl;  end
            TAP_N:   begin tap_row = op_reg.ru;  tap_col = op_reg.col; end
            TAP_NE:  begin tap_row = op_reg.ru;  tap_col = op_reg.cr;  end
            TAP_W:   begin tap_row = op_reg.row; tap_col = op_reg.cl;  end
            TAP_C:   begin tap_row = op_reg.row; tap_col = op_reg.col; end
            TAP_E:   begin tap_row = op_reg.row; tap_col = op_reg.cr;  end
            TAP_SW:  begin tap_row = op_reg.rdn; tap_col = op_reg.cl;  end
            TAP_S:   begin tap_row = op_reg.rdn; tap_col = op_reg.col; end
            TAP_SE:  begin tap_row = op_reg.rdn; tap_col = op_reg.cr;  end
            default: begin tap_row = op_reg.row; tap_col = op_reg.col; end
        endcase
        case (rd_tap_reg)
            TAP_NW, TAP_NE, TAP_SW, TAP_SE: tap_weight = op_reg.w_corner;
            TAP_N, TAP_W, TAP_E, TAP_S:     tap_weight = op_reg.w_edge;
            TAP_C:                          tap_weight = op_reg.w_center;
            default:                        tap_weight = '0;
        endcase
        rd_addr = {COORD_BITS'(tap_row), COORD_BITS'(tap_col)};
        wr_addr = {COORD_BITS'(q_op.row), COORD_BITS'(q_op.col)};
        prod    = PROD_BITS'(rdata_reg) * PROD_BITS'(tap_weight);
        acc_sum = acc_reg + ACC_BITS'(prod);
    end

    // two restoring divide steps per cycle
    always_comb begin
        logic [REM_BITS:0]   trial;
        logic [REM_BITS:0]   divisor;
        logic [REM_BITS-1:0] rem_v;
        logic [QUO_BITS-1:0] quo_v;
        divisor = (REM_BITS + 1)'(op_reg.total);
        rem_v   = rem_reg;
        quo_v   = quo_reg;
        for (int k = 0; k < 2; k++) begin
            trial = {rem_v, quo_v[QUO_BITS-1]};
            quo_v = quo_v << 1;
            if (trial >= divisor) begin
                rem_v    = REM_BITS'(trial - divisor);
                quo_v[0] = 1'b1;
            end else begin
                rem_v = REM_BITS'(trial);
            end
        end
        rem_step = rem_v;
        quo_step = quo_v;
    end

    // datapath
    always_comb begin
        op_next        = op_reg;
        tap_next       = tap_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        err_next       = err_reg;
        rd_valid_next  = (state_reg == ST_READ);
        rd_tap_next    = tap_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_err_next   = out_err_reg;
        if (rd_valid_reg) begin
            acc_next = acc_sum;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    op_next  = q_op;
                    tap_next = TAP_NW;
                    acc_next = '0;
                    quo_next = '0;
                    err_next = (q_op.kind == OP_REJECT);
                end
            end
            ST_READ: begin
                tap_next = tap_reg + TAP_BITS'(1);
            end
            ST_DRAIN: begin
                rem_next  = REM_BITS'(acc_sum >> QUO_BITS);
                quo_next  = acc_sum[QUO_BITS-1:0];
                iter_next = '0;
            end
            ST_DIV: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                iter_next = iter_reg + ITER_BITS'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_value_next = PIXEL_IN_BITS'(quo_reg[PIXEL_BITS-1:0]);
                    out_row_next   = op_reg.row;
                    out_col_next   = op_reg.col;
                    out_err_next   = err_reg;
                end
            end
            default: begin
                tap_next = tap_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        tap_reg       <= tap_next;
        rd_tap_reg    <= rd_tap_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        iter_reg      <= iter_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_err_reg   <= out_err_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[wr_addr] <= q_op.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= store_mem[rd_addr];
    end

    assign m_valid         = m_valid_reg;
    assign m_blurred_value = out_value_reg;
    assign m_out_row       = out_row_reg;
    assign m_out_col       = out_col_reg;
    assign m_coord_error   = out_err_reg;

endmodule

// File: rtl/core/blur3_checker.sv
// Port-level checker for the weighted 3x3 blur unit, bound to the top level.
module blur3_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_ready,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [blur3_pkg::PIXEL_IN_BITS-1:0]  m_blurred_value,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_row,
    input  logic [blur3_pkg::COORD_IN_BITS-1:0]  m_out_col,
    input  logic                                 m_coord_error
);
    import blur3_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or queue full after reset");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coord_error |-> m_blurred_value == '0)
        else $error("coordinate error result carries a nonzero value");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blurred_value)
            && $stable(m_out_row) && $stable(m_out_col) && $stable(m_coord_error))
        else $error("stalled result changed or dropped");

endmodule

bind weighted_3x3_blur_random_weights_unit blur3_checker u_blur3_checker (.*);
